FILE: src/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Widths, constants and beat types shared by the circumcenter pipeline.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int COORD_W  = 24;
    localparam int CENTER_W = 32;
    localparam int EDGE_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * EDGE_W;
    localparam int DOT_W    = PROD_W + 2;
    localparam int CPROD_W  = 2 * DOT_W;
    localparam int G_W      = CPROD_W + 1;
    localparam int CC_W     = CPROD_W + 2;
    localparam int NPROD_W  = G_W + COORD_W;
    localparam int NUM_W    = NPROD_W + 2 + 3;
    localparam int MUL_LAT  = 5;

    typedef logic signed [COORD_W-1:0]  t_coord;
    typedef logic signed [CENTER_W-1:0] t_center;

    typedef struct packed {
        t_coord a_x;
        t_coord a_y;
        t_coord a_z;
        t_coord b_x;
        t_coord b_y;
        t_coord b_z;
        t_coord c_x;
        t_coord c_y;
        t_coord c_z;
    } t_in;

    typedef struct packed {
        t_center center_x;
        t_center center_y;
        t_center center_z;
        logic    degenerate;
        logic    saturated;
    } t_out;

endpackage

FILE: src/triangle_circumcenter_3d.sv
// ----------------------------------------------------------------------------
// triangle_circumcenter_3d
// Circumcenter of a 3D triangle by barycentric weights, Q12.12 in, Q16.16 out.
//
// The block takes one triangle per clock while not stalled; the center is
// formed by two ranks of five-stage wide multipliers and then the 32-stage
// restoring divider that forms the quotient bits. A skid register at the
// output catches a result that the receiver stalls; while it is full the
// whole pipeline and the input stall with it. Collinear vertices give a zero
// center with degenerate set, and a center outside the Q16.16 range is
// clamped with saturated set.
// ----------------------------------------------------------------------------
module triangle_circumcenter_3d (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  tcc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output tcc_pkg::t_out o_data
);
    import tcc_pkg::*;

    localparam int NST = 4 + MUL_LAT + 1 + MUL_LAT + 2 + (CENTER_W + 1) + 1;
    localparam int VW  = $bits(t_in);

    logic                      en;
    logic [NST-1:0]            r_vld;
    logic                      r_skid_v;
    t_out                      r_skid;
    t_out                      r_out;
    t_out                      n_out;

    t_in                       r_in;
    t_coord                    v [3][3];
    t_in                       vd_s;
    logic [VW-1:0]             vd_bits;
    t_coord                    vd [3][3];
    logic signed [EDGE_W-1:0]  r_e [3][3];
    logic signed [PROD_W-1:0]  r_dp [3][3];
    logic signed [DOT_W-1:0]   r_d [3];
    logic signed [CPROD_W-1:0] cp [3];
    logic signed [G_W-1:0]     r_g [3];
    logic [CC_W-1:0]           r_cc;
    logic [CC_W-1:0]           ccd;
    logic signed [NPROD_W-1:0] np [3][3];
    logic signed [NUM_W-1:0]   r_n [3];
    logic [NUM_W-1:0]          r_nm [3];
    logic                      r_ns [3];
    logic                      deg_in;
    logic [CENTER_W-1:0]       quo [3];
    logic                      ovf [3];
    logic [1:0]                tag [3];
    logic [CENTER_W-1:0]       n_val [3];
    logic [2:0]                n_big;
    logic                      n_deg;

    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;
    assign o_valid = r_skid_v | r_vld[NST-1];
    assign o_data  = r_skid_v ? r_skid : r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_skid_v <= 1'b0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
            if (r_vld[NST-1] && i_stall) begin
                r_skid_v <= 1'b1;
            end
        end else if (!i_stall) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_vld[NST-1] && i_stall) begin
            r_skid <= r_out;
        end
    end

    always_comb begin
        v[0][0] = r_in.a_x;
        v[0][1] = r_in.a_y;
        v[0][2] = r_in.a_z;
        v[1][0] = r_in.b_x;
        v[1][1] = r_in.b_y;
        v[1][2] = r_in.b_z;
        v[2][0] = r_in.c_x;
        v[2][1] = r_in.c_y;
        v[2][2] = r_in.c_z;
        vd[0][0] = vd_s.a_x;
        vd[0][1] = vd_s.a_y;
        vd[0][2] = vd_s.a_z;
        vd[1][0] = vd_s.b_x;
        vd[1][1] = vd_s.b_y;
        vd[1][2] = vd_s.b_z;
        vd[2][0] = vd_s.c_x;
        vd[2][1] = vd_s.c_y;
        vd[2][2] = vd_s.c_z;
    end

    tcc_delay #(.W(VW), .D(4 + MUL_LAT)) u_vdly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_in),
        .o_d   (vd_bits)
    );

    assign vd_s = vd_bits;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_data;
            for (int k = 0; k < 3; k++) begin
                r_e[0][k]  <= EDGE_W'(v[2][k]) - EDGE_W'(v[1][k]);
                r_e[1][k]  <= EDGE_W'(v[0][k]) - EDGE_W'(v[2][k]);
                r_e[2][k]  <= EDGE_W'(v[1][k]) - EDGE_W'(v[0][k]);
                r_dp[0][k] <= r_e[1][k] * r_e[2][k];
                r_dp[1][k] <= r_e[0][k] * r_e[2][k];
                r_dp[2][k] <= r_e[0][k] * r_e[1][k];
            end
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= DOT_W'(0) - DOT_W'(r_dp[i][0]) - DOT_W'(r_dp[i][1])
                          - DOT_W'(r_dp[i][2]);
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_cmul
        tcc_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r_d[(i + 1) % 3]),
            .i_b   (r_d[(i + 2) % 3]),
            .o_p   (cp[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_g[i] <= G_W'(cp[(i + 1) % 3]) + G_W'(cp[(i + 2) % 3]);
            end
            r_cc <= CC_W'(cp[0]) + CC_W'(cp[1]) + CC_W'(cp[2]);
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_axis
        for (genvar i = 0; i < 3; i++) begin : g_nmul
            tcc_mul #(.AW(G_W), .BW(COORD_W)) u_mul (
                .i_clk (i_clk),
                .i_en  (en),
                .i_a   (r_g[i]),
                .i_b   (vd[i][k]),
                .o_p   (np[k][i])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k]  <= (NUM_W'(np[k][0]) + NUM_W'(np[k][1]) + NUM_W'(np[k][2])) <<< 3;
                r_nm[k] <= r_n[k][NUM_W-1] ? $unsigned(-r_n[k]) : $unsigned(r_n[k]);
                r_ns[k] <= r_n[k][NUM_W-1];
            end
        end
    end

    tcc_delay #(.W(CC_W), .D(MUL_LAT + 2)) u_ccdly (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_cc),
        .o_d   (ccd)
    );

    assign deg_in = (ccd == '0);

    for (genvar k = 0; k < 3; k++) begin : g_div
        tcc_div #(.NW(NUM_W), .DW(CC_W), .QW(CENTER_W), .TW(2)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_nm[k]),
            .i_den (ccd),
            .i_tag ({deg_in, r_ns[k]}),
            .o_quo (quo[k]),
            .o_ovf (ovf[k]),
            .o_tag (tag[k])
        );
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_big[k] = ovf[k] | (tag[k][0] ? (quo[k][CENTER_W-1] & (|quo[k][CENTER_W-2:0]))
                                           : quo[k][CENTER_W-1]);
            if (n_big[k]) begin
                n_val[k] = tag[k][0] ? {1'b1, {(CENTER_W-1){1'b0}}}
                                     : {1'b0, {(CENTER_W-1){1'b1}}};
            end else begin
                n_val[k] = tag[k][0] ? -quo[k] : quo[k];
            end
        end
        n_deg = tag[0][1] | tag[1][1] | tag[2][1];
        if (n_deg) begin
            n_out.center_x   = '0;
            n_out.center_y   = '0;
            n_out.center_z   = '0;
            n_out.degenerate = 1'b1;
            n_out.saturated  = 1'b0;
        end else begin
            n_out.center_x   = $signed(n_val[0]);
            n_out.center_y   = $signed(n_val[1]);
            n_out.center_z   = $signed(n_val[2]);
            n_out.degenerate = 1'b0;
            n_out.saturated  = |n_big;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: src/tcc_delay.sv
// ----------------------------------------------------------------------------
// tcc_delay
// Enabled shift line that carries side data alongside the arithmetic stages.
// ----------------------------------------------------------------------------
module tcc_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    logic [W-1:0] r_sr [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_d = r_sr[D-1];

endmodule

FILE: src/tcc_mul.sv
// ----------------------------------------------------------------------------
// tcc_mul
// Pipelined signed multiplier built from 32 by 32 bit partial products.
// ----------------------------------------------------------------------------
module tcc_mul #(
    parameter int AW = 52,
    parameter int BW = 52
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int NA = (AW + 31) / 32;
    localparam int NB = (BW + 31) / 32;
    localparam int MW = (NA + NB) * 32;
    localparam int PW = AW + BW;

    logic [AW-1:0]    n_am;
    logic [BW-1:0]    n_bm;
    logic [NA*32-1:0] r_am;
    logic [NB*32-1:0] r_bm;
    logic [63:0]      r_pp [NA][NB];
    logic [MW-1:0]    n_row [NA];
    logic [MW-1:0]    r_row [NA];
    logic [MW-1:0]    n_mag;
    logic [MW-1:0]    r_mag;
    logic [PW-1:0]    n_mt;
    logic [3:0]       r_neg;
    logic [PW-1:0]    r_p;

    assign n_am = i_a[AW-1] ? $unsigned(-i_a) : $unsigned(i_a);
    assign n_bm = i_b[BW-1] ? $unsigned(-i_b) : $unsigned(i_b);

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (MW'(r_pp[i][j]) << (32 * j));
            end
        end
    end

    always_comb begin
        n_mag = '0;
        for (int i = 0; i < NA; i++) begin
            n_mag = n_mag + (r_row[i] << (32 * i));
        end
    end

    assign n_mt = r_mag[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_am  <= (NA*32)'(n_am);
            r_bm  <= (NB*32)'(n_bm);
            r_neg <= {r_neg[2:0], i_a[AW-1] ^ i_b[BW-1]};
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= 64'(r_am[32*i +: 32]) * 64'(r_bm[32*j +: 32]);
                end
            end
            r_row <= n_row;
            r_mag <= n_mag;
            r_p   <= r_neg[3] ? -n_mt : n_mt;
        end
    end

    assign o_p = $signed(r_p);

endmodule

FILE: src/tcc_div.sv
// ----------------------------------------------------------------------------
// tcc_div
// Pipelined restoring divider, one quotient bit per stage, with overflow.
// ----------------------------------------------------------------------------
module tcc_div #(
    parameter int NW = 134,
    parameter int DW = 106,
    parameter int QW = 32,
    parameter int TW = 2
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf,
    output logic [TW-1:0] o_tag
);
    localparam int HW = NW - QW;
    localparam int RW = ((HW > DW) ? HW : DW) + 1;

    logic [RW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_low [QW+1];
    logic [QW-1:0] r_quo [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic          r_ovf [QW+1];
    logic [TW-1:0] r_tag [QW+1];
    logic [RW-1:0] n_hi;
    logic          n_ovf;

    // The upper dividend bits are checked first; a quotient that does not fit
    // in QW bits only raises the overflow flag.
    assign n_hi  = RW'(i_num[NW-1:QW]);
    assign n_ovf = n_hi >= RW'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_ovf ? '0 : n_hi;
            r_low[0] <= i_num[QW-1:0];
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_ovf[0] <= n_ovf;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [RW-1:0] n_try;
        logic          n_ge;

        assign n_try = {r_rem[k-1][RW-2:0], r_low[k-1][QW-1]};
        assign n_ge  = n_try >= RW'(r_den[k-1]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? (n_try - RW'(r_den[k-1])) : n_try;
                r_low[k] <= r_low[k-1] << 1;
                r_quo[k] <= {r_quo[k-1][QW-2:0], n_ge};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_quo = r_quo[QW];
    assign o_ovf = r_ovf[QW];
    assign o_tag = r_tag[QW];

endmodule

FILE: src/tcc_chk.sv
// ----------------------------------------------------------------------------
// tcc_chk
// Port-level checks on the result channel of the circumcenter block.
// ----------------------------------------------------------------------------
module tcc_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input tcc_pkg::t_out o_data
);
    import tcc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("Stalled result beat was dropped.");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("Stalled result beat changed.");

    a_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |-> (o_data.center_x == '0 && o_data.center_y == '0
            && o_data.center_z == '0 && !o_data.saturated))
        else $error("Degenerate beat carries a nonzero center or saturation.");

    a_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("Input stalled while no result is held.");

    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("Input stall rose without a stalled result.");

endmodule

bind triangle_circumcenter_3d tcc_chk u_tcc_chk (.*);
